>>> rtl/tfe_pkg.sv
// shared types and constants of the telemetry frame encoder
package tfe_pkg;

    // request codes, the fourth code carries no request
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_DATA   = 2'd1,
        OP_EMPTY  = 2'd2
    } t_opcode;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_DATA_FRAME_BYTE  = 1'b0,
        CFG_EMPTY_FRAME_BYTE = 1'b1
    } t_cfg_index;

    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE   = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR    = 8'h20;
    localparam logic [7:0] DATA_KIND_RST = 8'd16;
    localparam logic [7:0] EMPTY_KIND_RST = 8'd0;

    // frame bytes before the checksum
    localparam int FrameBytes = 7;
    localparam int ByteIdxW   = 3;
    localparam logic [ByteIdxW-1:0] HDR_LAST_IDX = 3'd1;
    localparam logic [ByteIdxW-1:0] CSUM_IDX     = 3'd7;

    // queue between front and back, depth is a power of two
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);

    // one classified request
    typedef struct packed {
        logic                        hdr;
        logic [FrameBytes-1:0][7:0]  bytes;
    } t_frame;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_BODY,
        S_ESC
    } t_state;

endpackage

>>> rtl/telemetry_frame_encoder_unit.sv
// top level of the telemetry frame encoder
//
//  channel   direction  handshake                 payload
//  request   in         i_valid / o_stall         i_opcode i_sensor_id i_type_id i_value
//  byte      out        o_valid / i_stall         o_line_byte o_last
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// one line byte per cycle while a frame is sent and i_stall is low; the single
// byte sequencer first loads each frame from the queue, then walks and stuffs
// its bytes: a header gives 2 line bytes, a data or empty frame 8 to 16.
// the two-entry queue lets the next requests be taken while a frame drains.
// synchronous active-low reset empties the queue and the output register and
// restores the kind bytes; a stall on the byte side holds the output register.
module telemetry_frame_encoder_unit
    import tfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_sensor_id,
    input  logic [15:0] i_type_id,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_line_byte,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_nonempty;
    t_frame push_frame;
    t_frame head_frame;

    // intake and classification
    tfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_sensor_id (i_sensor_id),
        .i_type_id   (i_type_id),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_frame     (push_frame)
    );

    // frame queue
    tfe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_frame    (push_frame),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_frame    (head_frame)
    );

    // byte sequencer
    tfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_frame      (head_frame),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_line_byte  (o_line_byte),
        .o_last       (o_last)
    );

endmodule

>>> rtl/tfe_front.sv
// request intake: configuration registers, classification and frame assembly
module tfe_front
    import tfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_sensor_id,
    input  logic [15:0] i_type_id,
    input  logic [31:0] i_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_frame      o_frame
);

    logic [7:0] r_data_kind;
    logic [7:0] r_empty_kind;
    logic       accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_kind  <= DATA_KIND_RST;
            r_empty_kind <= EMPTY_KIND_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DATA_FRAME_BYTE:  r_data_kind  <= i_cfg_data;
                CFG_EMPTY_FRAME_BYTE: r_empty_kind <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;

    // classify the request and lay out its raw bytes
    always_comb begin
        o_push        = 1'b0;
        o_frame.hdr   = 1'b0;
        o_frame.bytes = '0;
        unique case (t_opcode'(i_opcode))
            OP_HEADER: begin
                o_push        = accept;
                o_frame.hdr   = 1'b1;
                o_frame.bytes = {40'd0, i_sensor_id, START_BYTE};
            end
            OP_DATA: begin
                o_push        = accept;
                o_frame.bytes = {i_value, i_type_id, r_data_kind};
            end
            OP_EMPTY: begin
                o_push        = accept;
                o_frame.bytes = {32'd0, i_type_id, r_empty_kind};
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/tfe_queue.sv
// short frame queue between front and back
module tfe_queue
    import tfe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_nonempty,
    output t_frame o_frame
);

    t_frame             r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QPtrW:0]     r_count;

    assign o_full     = (r_count == (QPtrW+1)'(QDepth));
    assign o_nonempty = (r_count != '0);
    assign o_frame    = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tfe_back.sv
// byte sequencer: stuffing, checksum and output register
module tfe_back
    import tfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_nonempty,
    input  t_frame      i_frame,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_line_byte,
    output logic        o_last
);

    t_state                r_state, n_state;
    t_frame                r_frame, n_frame;
    logic [ByteIdxW-1:0]   r_idx, n_idx;
    logic [7:0]            r_sum, n_sum;
    logic [7:0]            r_esc_byte, n_esc_byte;
    logic                  r_esc_last, n_esc_last;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_line_byte, n_line_byte;
    logic                  r_last, n_last;

    logic       adv;
    logic [7:0] cur_byte;
    logic       cur_is_csum;
    logic       cur_special;
    logic [8:0] sum_wide;

    assign adv         = !r_out_valid || !i_stall;
    assign cur_is_csum = (r_idx == CSUM_IDX);
    assign cur_byte    = cur_is_csum ? ~r_sum : r_frame.bytes[r_idx];
    assign cur_special = (cur_byte == START_BYTE) || (cur_byte == ESCAPE_BYTE);
    // end-around-carry add of the current byte
    assign sum_wide    = {1'b0, r_sum} + {1'b0, cur_byte};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_nonempty) begin
                    n_state = i_frame.hdr ? S_HDR : S_BODY;
                end
            end
            S_HDR: begin
                if (adv && r_idx == HDR_LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_BODY: begin
                if (adv) begin
                    if (cur_special) begin
                        n_state = S_ESC;
                    end else if (cur_is_csum) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ESC: begin
                if (adv) begin
                    n_state = r_esc_last ? S_IDLE : S_BODY;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop       = 1'b0;
        n_frame     = r_frame;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_esc_byte  = r_esc_byte;
        n_esc_last  = r_esc_last;
        n_out_valid = adv ? 1'b0 : r_out_valid;
        n_line_byte = r_line_byte;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_nonempty) begin
                    o_pop   = 1'b1;
                    n_frame = i_frame;
                    n_idx   = '0;
                    n_sum   = '0;
                end
            end
            S_HDR: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_line_byte = r_frame.bytes[r_idx];
                    n_last      = (r_idx == HDR_LAST_IDX);
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_BODY: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    n_sum       = sum_wide[7:0] + {7'd0, sum_wide[8]};
                    if (cur_special) begin
                        n_line_byte = ESCAPE_BYTE;
                        n_last      = 1'b0;
                        n_esc_byte  = cur_byte ^ ESCAPE_XOR;
                        n_esc_last  = cur_is_csum;
                    end else begin
                        n_line_byte = cur_byte;
                        n_last      = cur_is_csum;
                    end
                end
            end
            S_ESC: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_line_byte = r_esc_byte;
                    n_last      = r_esc_last;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_frame     <= n_frame;
        r_idx       <= n_idx;
        r_sum       <= n_sum;
        r_esc_byte  <= n_esc_byte;
        r_esc_last  <= n_esc_last;
        r_line_byte <= n_line_byte;
        r_last      <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_line_byte = r_line_byte;
    assign o_last      = r_last;

endmodule
